/* rtl/core/per_thread_probe_sequence_assembler_macros.svh */
// Assertion macros for the probe sequence assembler.
`ifndef PER_THREAD_PROBE_SEQUENCE_ASSEMBLER_MACROS_SVH
`define PER_THREAD_PROBE_SEQUENCE_ASSEMBLER_MACROS_SVH
`ifndef NO_ASSERTIONS
`define PTPSA_ASSERT(lbl, clk, rst_n, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);
`define PTPSA_NEVER(lbl, clk, rst_n, expr, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) !(expr)) else $error(msg);
`else
`define PTPSA_ASSERT(lbl, clk, rst_n, prop, msg)
`define PTPSA_NEVER(lbl, clk, rst_n, expr, msg)
`endif
`endif

/* rtl/core/ptpsa_pkg.sv */
`timescale 1ns / 1ps
`default_nettype none
package ptpsa_pkg;

    localparam int MAX_PROBES_DEF   = 16;
    localparam int THREAD_SLOTS_DEF = 64;

    localparam int SLOT_W    = 6;
    localparam int POS_IN_W  = 5;
    localparam int DATA_W    = 64;
    localparam int OUT_POS_W = 4;
    localparam int NUM_W     = 5;
    localparam int LEN_W     = 7;
    localparam int POS_IDX_W = 6;

    localparam logic [NUM_W-1:0] NUM_PROBES_RST = 5'd16;

    localparam int RUNQ_DEPTH = 2;
    localparam int RUNQ_PW    = 1;

    localparam int OQ_DEPTH = 4;
    localparam int OQ_PW    = 2;
    localparam int OQ_CW    = 3;

    typedef struct packed {
        logic [SLOT_W-1:0]   thread_slot;
        logic [POS_IN_W-1:0] probe_position;
        logic [DATA_W-1:0]   event_time;
        logic [DATA_W-1:0]   event_value;
    } t_in_item;

    typedef struct packed {
        logic [SLOT_W-1:0]    out_thread;
        logic [OUT_POS_W-1:0] out_position;
        logic [DATA_W-1:0]    out_time;
        logic [DATA_W-1:0]    out_value;
        logic                 last_of_run;
    } t_out_item;

    typedef struct packed {
        logic [DATA_W-1:0] m_time;
        logic [DATA_W-1:0] m_value;
    } t_measure;

    typedef struct packed {
        logic                 en;
        logic [SLOT_W-1:0]    slot;
        logic [POS_IDX_W-1:0] pos;
        t_measure             data;
    } t_store_wr;

    typedef struct packed {
        logic [SLOT_W-1:0] slot;
        logic [LEN_W-1:0]  len;
    } t_run;

    typedef struct packed {
        logic              busy;
        logic [SLOT_W-1:0] slot;
    } t_back_stat;

endpackage
`default_nettype wire

/* rtl/core/ptpsa_front.sv */
`timescale 1ns / 1ps
`default_nettype none
module ptpsa_front #(
    parameter int MAX_PROBES   = ptpsa_pkg::MAX_PROBES_DEF,
    parameter int THREAD_SLOTS = ptpsa_pkg::THREAD_SLOTS_DEF
) (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              i_push,
    output logic                              o_full,
    input  ptpsa_pkg::t_in_item               i_item,
    input  logic [ptpsa_pkg::LEN_W-1:0]       i_len,
    output logic [ptpsa_pkg::SLOT_W-1:0]      o_chk_slot,
    input  logic                              i_slot_busy,
    input  logic                              i_runq_full,
    output ptpsa_pkg::t_store_wr              o_store_wr,
    output logic                              o_run_push,
    output ptpsa_pkg::t_run                   o_run
);
    import ptpsa_pkg::*;

    localparam int TS_EFF = (THREAD_SLOTS < (1 << SLOT_W)) ? THREAD_SLOTS : (1 << SLOT_W);
    localparam int SIW    = (TS_EFF > 1) ? $clog2(TS_EFF) : 1;
    localparam int CW     = $clog2(MAX_PROBES + 1);
    localparam int DEPTH  = 1 << SIW;

    logic [CW-1:0]    cnt_mem [DEPTH];
    logic [DEPTH-1:0] r_cvld;

    logic             r_vld;
    t_in_item         r_item;
    logic [CW-1:0]    r_cnt_rd;
    logic             r_cvld_rd;
    logic             r_fwd;
    logic [CW-1:0]    r_fwd_cnt;

    logic             slot_ok;
    logic             stall;
    logic             fire;
    logic             accept;
    logic [CW-1:0]    cur_cnt;
    logic             hit;
    logic [CW-1:0]    nxt_cnt;
    logic             done;
    logic             wr_en;
    logic [CW-1:0]    wr_cnt;
    logic [SIW-1:0]   rd_idx;
    logic [SIW-1:0]   wr_idx;

    assign rd_idx = i_item.thread_slot[SIW-1:0];
    assign wr_idx = r_item.thread_slot[SIW-1:0];

    always_comb begin
        slot_ok = 32'(r_item.thread_slot) < THREAD_SLOTS;
        stall   = slot_ok && (i_runq_full || i_slot_busy);
        fire    = r_vld && !stall;
        o_full  = r_vld && stall;
        accept  = i_push && !o_full;
        cur_cnt = r_fwd ? r_fwd_cnt : (r_cvld_rd ? r_cnt_rd : '0);
        hit     = (32'(r_item.probe_position) < 32'(i_len))
               && (32'(r_item.probe_position) == 32'(cur_cnt));
        nxt_cnt = hit ? cur_cnt + CW'(1) : '0;
        done    = hit && (32'(nxt_cnt) == 32'(i_len));
        wr_en   = fire && slot_ok;
        wr_cnt  = done ? '0 : nxt_cnt;
    end

    always_comb begin
        o_store_wr.en   = wr_en && hit;
        o_store_wr.slot = r_item.thread_slot;
        o_store_wr.pos  = POS_IDX_W'(cur_cnt);
        o_store_wr.data = '{m_time: r_item.event_time, m_value: r_item.event_value};
        o_run_push      = wr_en && done;
        o_run.slot      = r_item.thread_slot;
        o_run.len       = i_len;
        o_chk_slot      = r_item.thread_slot;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld  <= 1'b0;
            r_cvld <= '0;
            r_fwd  <= 1'b0;
        end else begin
            if (accept) begin
                r_vld <= 1'b1;
            end else if (fire) begin
                r_vld <= 1'b0;
            end
            if (wr_en) begin
                r_cvld[wr_idx] <= 1'b1;
            end
            if (accept) begin
                r_fwd <= wr_en && (wr_idx == rd_idx);
            end
        end
    end

    // count memory, read on accept; same-cycle write is forwarded
    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_item    <= i_item;
            r_cnt_rd  <= cnt_mem[rd_idx];
            r_cvld_rd <= r_cvld[rd_idx];
            r_fwd_cnt <= wr_cnt;
        end
        if (wr_en) begin
            cnt_mem[wr_idx] <= wr_cnt;
        end
    end

endmodule
`default_nettype wire

/* rtl/core/ptpsa_runq.sv */
`timescale 1ns / 1ps
`default_nettype none
module ptpsa_runq (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         i_push,
    input  ptpsa_pkg::t_run              i_run,
    output logic                         o_full,
    input  logic                         i_pop,
    output logic                         o_vld,
    output ptpsa_pkg::t_run              o_run,
    input  logic [ptpsa_pkg::SLOT_W-1:0] i_chk_slot,
    input  ptpsa_pkg::t_back_stat        i_back,
    output logic                         o_slot_busy
);
    import ptpsa_pkg::*;

    t_run                  r_ent [RUNQ_DEPTH];
    logic [RUNQ_DEPTH-1:0] r_ev;
    logic [RUNQ_PW-1:0]    r_wp;
    logic [RUNQ_PW-1:0]    r_rp;
    logic                  do_pop;

    assign o_full = &r_ev;
    assign o_vld  = r_ev[r_rp];
    assign o_run  = r_ent[r_rp];
    assign do_pop = i_pop && o_vld;

    // slot lookup over queued runs and the one being read out
    always_comb begin
        o_slot_busy = i_back.busy && (i_back.slot == i_chk_slot);
        for (int k = 0; k < RUNQ_DEPTH; k++) begin
            if (r_ev[k] && (r_ent[k].slot == i_chk_slot)) begin
                o_slot_busy = 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ev <= '0;
            r_wp <= '0;
            r_rp <= '0;
        end else begin
            if (i_push && !o_full) begin
                r_ev[r_wp] <= 1'b1;
                r_wp       <= r_wp + RUNQ_PW'(1);
            end
            if (do_pop) begin
                r_ev[r_rp] <= 1'b0;
                r_rp       <= r_rp + RUNQ_PW'(1);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_push && !o_full) begin
            r_ent[r_wp] <= i_run;
        end
    end

endmodule
`default_nettype wire

/* rtl/core/ptpsa_back.sv */
`timescale 1ns / 1ps
`default_nettype none
`include "per_thread_probe_sequence_assembler_macros.svh"
module ptpsa_back #(
    parameter int MAX_PROBES   = ptpsa_pkg::MAX_PROBES_DEF,
    parameter int THREAD_SLOTS = ptpsa_pkg::THREAD_SLOTS_DEF
) (
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    input  ptpsa_pkg::t_store_wr   i_store_wr,
    input  logic                   i_run_vld,
    input  ptpsa_pkg::t_run        i_run,
    output logic                   o_run_take,
    output ptpsa_pkg::t_back_stat  o_stat,
    input  logic                   i_pop,
    output logic                   o_empty,
    output ptpsa_pkg::t_out_item   o_result
);
    import ptpsa_pkg::*;

    localparam int TS_EFF = (THREAD_SLOTS < (1 << SLOT_W)) ? THREAD_SLOTS : (1 << SLOT_W);
    localparam int SIW    = (TS_EFF > 1) ? $clog2(TS_EFF) : 1;
    localparam int PIW    = (MAX_PROBES > 1) ? $clog2(MAX_PROBES) : 1;
    localparam int ADDR_W = SIW + PIW;
    localparam int MDEPTH = 1 << ADDR_W;

    t_measure           store [MDEPTH];

    logic               r_busy;
    logic [SLOT_W-1:0]  r_slot;
    logic [LEN_W-1:0]   r_len;
    logic [PIW-1:0]     r_idx;

    logic               r_rd_vld;
    logic [SLOT_W-1:0]  r_rd_slot;
    logic [PIW-1:0]     r_rd_pos;
    logic               r_rd_last;
    t_measure           r_rd_data;

    t_out_item          r_oq [OQ_DEPTH];
    logic [OQ_PW-1:0]   r_wp;
    logic [OQ_PW-1:0]   r_rp;
    logic [OQ_CW-1:0]   r_oc;

    logic               take;
    logic               issue;
    logic               rd_last;
    logic               oq_pop;
    logic [ADDR_W-1:0]  wr_addr;
    logic [ADDR_W-1:0]  rd_addr;

    always_comb begin
        take    = !r_busy && i_run_vld;
        issue   = r_busy && ((32'(r_oc) + 32'(r_rd_vld)) < OQ_DEPTH);
        rd_last = (32'(r_idx) + 32'd1) == 32'(r_len);
        oq_pop  = i_pop && (r_oc != '0);
        wr_addr = {i_store_wr.slot[SIW-1:0], i_store_wr.pos[PIW-1:0]};
        rd_addr = {r_slot[SIW-1:0], r_idx};
    end

    assign o_run_take  = take;
    assign o_stat.busy = r_busy;
    assign o_stat.slot = r_slot;
    assign o_empty     = (r_oc == '0);
    assign o_result    = r_oq[r_rp];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy   <= 1'b0;
            r_rd_vld <= 1'b0;
            r_wp     <= '0;
            r_rp     <= '0;
            r_oc     <= '0;
        end else begin
            if (take) begin
                r_busy <= 1'b1;
            end else if (issue && rd_last) begin
                r_busy <= 1'b0;
            end
            r_rd_vld <= issue;
            if (r_rd_vld) begin
                r_wp <= r_wp + OQ_PW'(1);
            end
            if (oq_pop) begin
                r_rp <= r_rp + OQ_PW'(1);
            end
            case ({r_rd_vld, oq_pop})
                2'b10:   r_oc <= r_oc + OQ_CW'(1);
                2'b01:   r_oc <= r_oc - OQ_CW'(1);
                default: r_oc <= r_oc;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (take) begin
            r_slot <= i_run.slot;
            r_len  <= i_run.len;
            r_idx  <= '0;
        end else if (issue) begin
            r_idx <= r_idx + PIW'(1);
        end
        if (i_store_wr.en) begin
            store[wr_addr] <= i_store_wr.data;
        end
        if (issue) begin
            r_rd_data <= store[rd_addr];
            r_rd_slot <= r_slot;
            r_rd_pos  <= r_idx;
            r_rd_last <= rd_last;
        end
        if (r_rd_vld) begin
            r_oq[r_wp] <= '{out_thread:   r_rd_slot,
                           out_position: OUT_POS_W'(r_rd_pos),
                           out_time:     r_rd_data.m_time,
                           out_value:    r_rd_data.m_value,
                           last_of_run:  r_rd_last};
        end
    end

    `PTPSA_ASSERT(a_oq_room, i_clk, i_rst_n, r_rd_vld |-> (32'(r_oc) < OQ_DEPTH), "result queue overrun")
    `PTPSA_ASSERT(a_run_end, i_clk, i_rst_n, (issue && rd_last) |=> !r_busy, "run did not end")
    `PTPSA_NEVER(a_store_race, i_clk, i_rst_n, r_busy && i_store_wr.en && (i_store_wr.slot == r_slot), "store written during readout")
    `PTPSA_ASSERT(a_last_flag, i_clk, i_rst_n, (take && (i_run.len == LEN_W'(1))) |=> rd_last, "single-entry run not marked last")

endmodule
`default_nettype wire

/* rtl/core/per_thread_probe_sequence_assembler.sv */
// Per-thread probe sequence assembler.
// Input queue side: item (thread slot, probe position, time, value) is taken on
// push while full is low. Results leave through empty/pop: the oldest result sits
// on o_result while empty is low and is taken when pop is high.
// Config: i_cfg_data (num_probes) is written on i_cfg_valid; o_cfg_ready is always
// high. Write it only while the block is idle.
// Throughput: one item per cycle. An item stalls (full high) while its thread
// still has a completed run waiting in the run queue or being read out, or when
// the two-entry run queue is full.
// Results of a completed run go via the run queue, store read and result queue,
// one per cycle while it has room, set by the single store read port.
// A stalled pop backs up the 4-entry result queue and then the run readout; the
// front keeps taking items for other threads until the run queue fills.
// Reset: all thread progress counts read as zero right away through per-slot
// valid bits; no clearing pass. num_probes returns to 16.
`timescale 1ns / 1ps
`default_nettype none
module per_thread_probe_sequence_assembler #(
    parameter int MAX_PROBES   = ptpsa_pkg::MAX_PROBES_DEF,
    parameter int THREAD_SLOTS = ptpsa_pkg::THREAD_SLOTS_DEF
) (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        push,
    output logic                        full,
    input  ptpsa_pkg::t_in_item         i_item,
    output logic                        empty,
    input  logic                        pop,
    output ptpsa_pkg::t_out_item        o_result,
    input  logic                        i_cfg_valid,
    output logic                        o_cfg_ready,
    input  logic [ptpsa_pkg::NUM_W-1:0] i_cfg_data
);
    import ptpsa_pkg::*;

    logic [NUM_W-1:0]  r_num_probes;
    logic [LEN_W-1:0]  eff_len;

    logic [SLOT_W-1:0] chk_slot;
    logic              slot_busy;
    logic              runq_full;
    t_store_wr         store_wr;
    logic              run_push;
    t_run              run_in;
    logic              run_vld;
    t_run              run_out;
    logic              run_take;
    t_back_stat        back_stat;

    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_num_probes <= NUM_PROBES_RST;
        end else if (i_cfg_valid && o_cfg_ready) begin
            r_num_probes <= i_cfg_data;
        end
    end

    // saturate to 1..MAX_PROBES
    always_comb begin
        if (r_num_probes == '0) begin
            eff_len = LEN_W'(1);
        end else if (32'(r_num_probes) > MAX_PROBES) begin
            eff_len = LEN_W'(MAX_PROBES);
        end else begin
            eff_len = LEN_W'(r_num_probes);
        end
    end

    ptpsa_front #(
        .MAX_PROBES   (MAX_PROBES),
        .THREAD_SLOTS (THREAD_SLOTS)
    ) u_front (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_push       (push),
        .o_full       (full),
        .i_item       (i_item),
        .i_len        (eff_len),
        .o_chk_slot   (chk_slot),
        .i_slot_busy  (slot_busy),
        .i_runq_full  (runq_full),
        .o_store_wr   (store_wr),
        .o_run_push   (run_push),
        .o_run        (run_in)
    );

    ptpsa_runq u_runq (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_push       (run_push),
        .i_run        (run_in),
        .o_full       (runq_full),
        .i_pop        (run_take),
        .o_vld        (run_vld),
        .o_run        (run_out),
        .i_chk_slot   (chk_slot),
        .i_back       (back_stat),
        .o_slot_busy  (slot_busy)
    );

    ptpsa_back #(
        .MAX_PROBES   (MAX_PROBES),
        .THREAD_SLOTS (THREAD_SLOTS)
    ) u_back (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_store_wr   (store_wr),
        .i_run_vld    (run_vld),
        .i_run        (run_out),
        .o_run_take   (run_take),
        .o_stat       (back_stat),
        .i_pop        (pop),
        .o_empty      (empty),
        .o_result     (o_result)
    );

endmodule
`default_nettype wire

/* sim/per_thread_probe_sequence_assembler_checker.sv */
`timescale 1ns / 1ps
module per_thread_probe_sequence_assembler_checker (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        push,
    input  logic                        full,
    input  ptpsa_pkg::t_in_item         i_item,
    input  logic                        empty,
    input  logic                        pop,
    input  ptpsa_pkg::t_out_item        o_result,
    input  logic                        i_cfg_valid,
    input  logic                        o_cfg_ready,
    input  logic [ptpsa_pkg::NUM_W-1:0] i_cfg_data,
    output int                          o_fail_count,
    output int                          o_pending,
    output int                          o_results,
    output int                          o_runs,
    output int                          o_full_stalls
);
    import ptpsa_pkg::*;

    localparam int SLOTS = THREAD_SLOTS_DEF;
    localparam int DEPTH = MAX_PROBES_DEF;

    t_measure         measures [SLOTS][DEPTH];
    logic [NUM_W-1:0] progress [SLOTS];
    logic [NUM_W-1:0] probe_count;
    t_out_item        due_q [$];
    int               fail_cnt   = 0;
    int               result_cnt = 0;
    int               run_cnt    = 0;
    int               stall_cnt  = 0;

    function automatic int run_length(logic [NUM_W-1:0] n);
        if (n == 0) return 1;
        if (n > DEPTH) return DEPTH;
        return int'(n);
    endfunction

    task automatic flag(string msg);
        fail_cnt++;
        $display("[%0t] mismatch: %s", $time, msg);
    endtask

    task automatic assemble_event(t_in_item ev);
        int        len;
        int        cnt;
        int        slot;
        int        pos;
        t_out_item r;
        slot = int'(ev.thread_slot);
        pos  = int'(ev.probe_position);
        len  = run_length(probe_count);
        cnt  = int'(progress[slot]);
        if (pos < len && pos == cnt) begin
            measures[slot][cnt].m_time  = ev.event_time;
            measures[slot][cnt].m_value = ev.event_value;
            cnt++;
        end else begin
            cnt = 0;
        end
        if (cnt == len) begin
            for (int k = 0; k < len; k++) begin
                r.out_thread   = slot[SLOT_W-1:0];
                r.out_position = k[OUT_POS_W-1:0];
                r.out_time     = measures[slot][k].m_time;
                r.out_value    = measures[slot][k].m_value;
                r.last_of_run  = (k == len - 1);
                due_q = {due_q, r};
            end
            cnt = 0;
        end
        progress[slot] = cnt[NUM_W-1:0];
    endtask

    task automatic check_result(t_out_item got);
        t_out_item want;
        if (due_q.size() == 0) begin
            flag($sformatf("result with nothing due: thread %0d position %0d",
                           got.out_thread, got.out_position));
            return;
        end
        want = due_q.pop_front();
        result_cnt++;
        if (want.last_of_run) run_cnt++;
        if (got.out_thread !== want.out_thread)
            flag($sformatf("thread: got %0d, expected %0d", got.out_thread, want.out_thread));
        if (got.out_position !== want.out_position)
            flag($sformatf("thread %0d position: got %0d, expected %0d",
                           want.out_thread, got.out_position, want.out_position));
        if (got.out_time !== want.out_time)
            flag($sformatf("thread %0d pos %0d time: got %h, expected %h",
                           want.out_thread, want.out_position, got.out_time, want.out_time));
        if (got.out_value !== want.out_value)
            flag($sformatf("thread %0d pos %0d value: got %h, expected %h",
                           want.out_thread, want.out_position, got.out_value, want.out_value));
        if (got.last_of_run !== want.last_of_run)
            flag($sformatf("thread %0d pos %0d last: got %b, expected %b",
                           want.out_thread, want.out_position, got.last_of_run,
                           want.last_of_run));
    endtask

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            probe_count = NUM_PROBES_RST;
            foreach (progress[s]) progress[s] = '0;
            due_q.delete();
        end else begin
            if (pop && !empty) check_result(o_result);
            if (push && !full) assemble_event(i_item);
            if (push && full) stall_cnt++;
            if (i_cfg_valid && o_cfg_ready) probe_count = i_cfg_data;
        end
        o_fail_count  <= fail_cnt;
        o_pending     <= due_q.size();
        o_results     <= result_cnt;
        o_runs        <= run_cnt;
        o_full_stalls <= stall_cnt;
    end
endmodule

/* sim/tb_per_thread_probe_sequence_assembler.sv */
`timescale 1ns / 1ps
module tb_per_thread_probe_sequence_assembler;
    import ptpsa_pkg::*;

    localparam int CYCLE_LIMIT   = 400000;
    localparam int HOLD_CYCLES   = 400;
    localparam int PHASES        = 8;
    localparam int PHASE_ITEMS   = 51;
    localparam int UNKNOWN_PROBE = 16;

    logic             i_clk = 1'b0;
    logic             i_rst_n;
    logic             push;
    logic             full;
    t_in_item         i_item;
    logic             empty;
    logic             pop;
    t_out_item        o_result;
    logic             i_cfg_valid;
    logic             o_cfg_ready;
    logic [NUM_W-1:0] i_cfg_data;

    int fail_count;
    int pending;
    int results;
    int runs;
    int full_stalls;

    int               cycle_count = 0;
    int               items_sent  = 0;
    int               cfg_writes  = 0;
    int               cur_len     = MAX_PROBES_DEF;
    int               next_pos [THREAD_SLOTS_DEF];
    int               slot_pool [4];
    bit               tx_steady   = 1'b0;
    bit               rx_steady   = 1'b0;
    bit               hold_req    = 1'b0;
    int               rx_wait     = 0;
    logic [NUM_W-1:0] phase_cfg [PHASES] = '{5'd1, 5'd16, 5'd0, 5'd31, 5'd5, 5'd9, 5'd20, 5'd3};

    per_thread_probe_sequence_assembler i_dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .push        (push),
        .full        (full),
        .i_item      (i_item),
        .empty       (empty),
        .pop         (pop),
        .o_result    (o_result),
        .i_cfg_valid (i_cfg_valid),
        .o_cfg_ready (o_cfg_ready),
        .i_cfg_data  (i_cfg_data)
    );

    per_thread_probe_sequence_assembler_checker i_checker (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .push          (push),
        .full          (full),
        .i_item        (i_item),
        .empty         (empty),
        .pop           (pop),
        .o_result      (o_result),
        .i_cfg_valid   (i_cfg_valid),
        .o_cfg_ready   (o_cfg_ready),
        .i_cfg_data    (i_cfg_data),
        .o_fail_count  (fail_count),
        .o_pending     (pending),
        .o_results     (results),
        .o_runs        (runs),
        .o_full_stalls (full_stalls)
    );

    always #2 i_clk = ~i_clk;

    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count == CYCLE_LIMIT) begin
            $display("timeout after %0d cycles, %0d results still due", cycle_count, pending);
            $display("*** FAILED ***");
            $finish;
        end
    end

    function automatic int idle_len();
        int r;
        r = $urandom_range(0, 99);
        if (r < 50) return 0;
        if (r < 90) return $urandom_range(1, 3);
        return $urandom_range(8, 40);
    endfunction

    function automatic logic [63:0] rand_word();
        int r;
        r = $urandom_range(0, 9);
        if (r == 0) return '0;
        if (r == 1) return '1;
        return {$urandom, $urandom};
    endfunction

    // result side: random stalls, plus one long hold-off on request
    initial begin
        pop <= 1'b0;
        forever begin
            @(posedge i_clk);
            if (rx_wait > 0) begin
                pop <= 1'b0;
                rx_wait--;
            end else if (hold_req) begin
                pop      <= 1'b0;
                rx_wait  = HOLD_CYCLES - 1;
                hold_req = 1'b0;
            end else begin
                pop <= 1'b1;
                if (!rx_steady && $urandom_range(0, 3) == 0) rx_wait = idle_len();
            end
        end
    end

    task automatic offer_event(int slot, int pos, logic [63:0] t, logic [63:0] v);
        int       gap;
        t_in_item ev;
        gap = tx_steady ? 0 : idle_len();
        if (gap > 0) begin
            push <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        ev.thread_slot    = slot[SLOT_W-1:0];
        ev.probe_position = pos[POS_IN_W-1:0];
        ev.event_time     = t;
        ev.event_value    = v;
        push   <= 1'b1;
        i_item <= ev;
        do @(posedge i_clk); while (full);
        items_sent++;
        if (pos < cur_len && pos == next_pos[slot]) begin
            next_pos[slot]++;
            if (next_pos[slot] == cur_len) next_pos[slot] = 0;
        end else begin
            next_pos[slot] = 0;
        end
    endtask

    task automatic quiesce();
        push <= 1'b0;
        @(posedge i_clk);
        while (pending != 0) @(posedge i_clk);
        repeat (8) @(posedge i_clk);
    endtask

    task automatic write_probe_count(logic [NUM_W-1:0] n);
        quiesce();
        i_cfg_valid <= 1'b1;
        i_cfg_data  <= n;
        do @(posedge i_clk); while (!o_cfg_ready);
        i_cfg_valid <= 1'b0;
        cur_len = (n == 0) ? 1 : ((n > MAX_PROBES_DEF) ? MAX_PROBES_DEF : int'(n));
        cfg_writes++;
    endtask

    initial begin
        int s;
        int p;
        push        <= 1'b0;
        i_item      <= '0;
        i_cfg_valid <= 1'b0;
        i_cfg_data  <= '0;
        i_rst_n     <= 1'b0;
        foreach (next_pos[k]) next_pos[k] = 0;
        repeat (6) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // directed: three-probe runs, interleaved threads, broken sequences
        write_probe_count(5'd3);
        offer_event(0, 0, '1, '1);
        offer_event(0, 1, '1, '1);
        offer_event(0, 2, '1, '1);
        offer_event(63, 0, '0, '0);
        offer_event(1, 0, rand_word(), rand_word());
        offer_event(63, 1, '0, '0);
        offer_event(1, 1, rand_word(), rand_word());
        offer_event(63, 2, '0, '0);
        offer_event(1, 2, rand_word(), rand_word());
        offer_event(2, 0, rand_word(), rand_word());
        offer_event(2, 2, rand_word(), rand_word());
        offer_event(2, 1, rand_word(), rand_word());
        offer_event(2, 0, rand_word(), rand_word());
        offer_event(2, 1, rand_word(), rand_word());
        offer_event(2, 2, rand_word(), rand_word());
        offer_event(3, 0, rand_word(), rand_word());
        offer_event(3, UNKNOWN_PROBE, rand_word(), rand_word());
        offer_event(3, 0, rand_word(), rand_word());
        offer_event(3, 31, rand_word(), rand_word());
        offer_event(4, 0, rand_word(), rand_word());
        offer_event(4, 1, rand_word(), rand_word());
        // thread 4 now holds as many measures as the shorter list
        write_probe_count(5'd2);
        offer_event(4, 0, rand_word(), rand_word());
        offer_event(4, 0, rand_word(), rand_word());
        offer_event(4, 1, rand_word(), rand_word());

        for (int ph = 0; ph < PHASES; ph++) begin
            write_probe_count(ph == 5 ? 5'($urandom_range(2, 15)) : phase_cfg[ph]);
            foreach (slot_pool[k]) slot_pool[k] = $urandom_range(0, THREAD_SLOTS_DEF - 1);
            tx_steady = (ph == 1 || ph == 4);
            rx_steady = (ph == 2 || ph == 6);
            if (ph == 4) hold_req = 1'b1;
            repeat (PHASE_ITEMS) begin
                s = ($urandom_range(0, 9) < 7) ? slot_pool[$urandom_range(0, 3)]
                                               : $urandom_range(0, THREAD_SLOTS_DEF - 1);
                p = ($urandom_range(0, 9) < 8) ? next_pos[s] : $urandom_range(0, 31);
                offer_event(s, p, rand_word(), rand_word());
            end
        end
        tx_steady = 1'b0;
        rx_steady = 1'b0;
        quiesce();
        repeat (16) @(posedge i_clk);

        $display("%0d probe events over %0d list lengths; input stalled %0d cycles",
                 items_sent, cfg_writes, full_stalls);
        $display("%0d measures in %0d completed runs compared, %0d mismatches",
                 results, runs, fail_count);
        if (fail_count == 0) begin
            $display("*** PASSED ***");
        end else begin
            $display("*** FAILED ***");
        end
        $finish;
    end
endmodule
